// ----- design/osk_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// osk_pkg: shared types and codes of the ordered set block
// Operation and status codes, controller states, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package osk_pkg;

  // Operation codes on the input func field.
  localparam logic [1:0] FN_INS = 2'd0;
  localparam logic [1:0] FN_ERS = 2'd1;
  localparam logic [1:0] FN_QRY = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SCMP,
    S_CHK,
    S_INS,
    S_INS_WR,
    S_ERS,
    S_ERS_WR,
    S_QWAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       srch_init;
    logic       srch_rd;
    logic       srch_upd;
    logic       chk_rd;
    logic       ptr_init_ins;
    logic       ptr_init_ers;
    logic       ins_rd;
    logic       ins_wr;
    logic       ers_rd;
    logic       ers_wr;
    logic       key_wr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       q_rd;
    logic       res_set;
    logic [1:0] res_code;
    logic       res_from_rd;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       srch_done;
    logic       present;
    logic       full;
    logic       q_ok;
    logic       ins_more;
    logic       ers_more;
    logic       out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ----- design/osk_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// osk_ctrl: controller of the ordered set block
// Sequences the binary search, the entry shifts of insert and erase, the rank
// lookup and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module osk_ctrl
  import osk_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.func == FN_INS || stat.func == FN_ERS) begin
          state_nxt = S_SRCH;
        end else if (stat.func == FN_QRY && stat.q_ok) begin
          state_nxt = S_QWAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SRCH: begin
        state_nxt = stat.srch_done ? S_CHK : S_SCMP;
      end
      S_SCMP: state_nxt = S_SRCH;
      S_CHK: begin
        if (stat.func == FN_INS) begin
          state_nxt = (stat.present || stat.full) ? S_DONE : S_INS;
        end else begin
          state_nxt = stat.present ? S_ERS : S_DONE;
        end
      end
      S_INS: state_nxt = stat.ins_more ? S_INS_WR : S_DONE;
      S_INS_WR: state_nxt = S_INS;
      S_ERS: state_nxt = stat.ers_more ? S_ERS_WR : S_DONE;
      S_ERS_WR: state_nxt = S_ERS;
      S_QWAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load_item = in_valid;
      end
      S_DISPATCH: begin
        if (stat.func == FN_INS || stat.func == FN_ERS) begin
          cmd.srch_init = 1'b1;
        end else if (stat.func == FN_QRY) begin
          if (stat.q_ok) begin
            cmd.q_rd = 1'b1;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_RANK;
          end
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
        end
      end
      S_SRCH: begin
        if (stat.srch_done) begin
          cmd.chk_rd = 1'b1;
        end else begin
          cmd.srch_rd = 1'b1;
        end
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
      end
      S_CHK: begin
        if (stat.func == FN_INS) begin
          if (stat.present) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
          end else if (stat.full) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_FULL;
          end else begin
            cmd.ptr_init_ins = 1'b1;
          end
        end else begin
          if (stat.present) begin
            cmd.ptr_init_ers = 1'b1;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
          end
        end
      end
      S_INS: begin
        if (stat.ins_more) begin
          cmd.ins_rd = 1'b1;
        end else begin
          cmd.key_wr   = 1'b1;
          cmd.cnt_inc  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
      end
      S_ERS: begin
        if (stat.ers_more) begin
          cmd.ers_rd = 1'b1;
        end else begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
        end
      end
      S_ERS_WR: begin
        cmd.ers_wr = 1'b1;
      end
      S_QWAIT: begin
        cmd.res_set     = 1'b1;
        cmd.res_code    = ST_OK;
        cmd.res_from_rd = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/osk_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// osk_dp: datapath of the ordered set block
// Key memory with one write and one registered read port, key count, search
// bounds, shift pointer, result registers and the output register.
// ----------------------------------------------------------------------------
module osk_dp
  import osk_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic        [1:0]  in_func,
  input  wire logic signed [31:0] in_operand,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_status,
  output logic signed      [31:0] out_value,
  output logic             [8:0]  out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic signed [31:0] mem [CAPACITY];

  logic        [1:0]  func_r;
  logic signed [31:0] key_r;
  logic        [CW-1:0] count_r;
  logic        [CW-1:0] lo_r;
  logic        [CW-1:0] hi_r;
  logic        [CW-1:0] ptr_r;
  logic signed [31:0] rd_data_r;
  logic        [1:0]  res_status_r;
  logic signed [31:0] res_value_r;
  logic               out_valid_r;
  logic        [1:0]  out_status_r;
  logic signed [31:0] out_value_r;
  logic        [8:0]  out_count_r;

  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid;
  logic [CW-1:0]   ptr_dec;
  logic [CW-1:0]   ptr_inc;
  logic [CW-1:0]   q_idx;
  logic [31:0]     cnt_ext;
  logic [CW+8:0]   cnt_wide;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  // Address arithmetic.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign ptr_dec  = ptr_r - 1'b1;
  assign ptr_inc  = ptr_r + 1'b1;
  assign q_idx    = count_r - key_r[CW-1:0];
  assign cnt_ext  = 32'(count_r);
  assign cnt_wide = {9'd0, count_r};

  // Read port selection.
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = lo_r[AW-1:0];
    if (cmd.srch_rd) begin
      rd_addr = mid[AW-1:0];
    end else if (cmd.ins_rd) begin
      rd_addr = ptr_dec[AW-1:0];
    end else if (cmd.ers_rd) begin
      rd_addr = ptr_inc[AW-1:0];
    end else if (cmd.q_rd) begin
      rd_addr = q_idx[AW-1:0];
    end else if (!cmd.chk_rd) begin
      rd_en = 1'b0;
    end
  end

  // Write port selection.
  always_comb begin
    wr_en   = cmd.ins_wr | cmd.ers_wr | cmd.key_wr;
    wr_addr = ptr_r[AW-1:0];
    wr_data = cmd.key_wr ? key_r : rd_data_r;
  end

  // Key memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Item, search bounds and shift pointer.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      key_r  <= in_operand;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd.srch_upd) begin
      if (rd_data_r < key_r) begin
        lo_r <= mid + 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.ptr_init_ins) begin
      ptr_r <= count_r;
    end else if (cmd.ptr_init_ers) begin
      ptr_r <= lo_r;
    end else if (cmd.ins_wr) begin
      ptr_r <= ptr_dec;
    end else if (cmd.ers_wr) begin
      ptr_r <= ptr_inc;
    end
  end

  // Key count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  // Result of the current item.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_value_r  <= cmd.res_from_rd ? rd_data_r : 32'sd0;
    end
  end

  // Output register; a pending transfer holds up only the hand-off of the next item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_count_r  <= cnt_wide[8:0];
    end
  end

  // Status to the controller.
  always_comb begin
    stat.func      = func_r;
    stat.srch_done = !(lo_r < hi_r);
    stat.present   = (lo_r < count_r) && (rd_data_r == key_r);
    stat.full      = (count_r == CAP_CNT);
    stat.q_ok      = !key_r[31] && (key_r != 32'sd0) && ($unsigned(key_r) <= cnt_ext);
    stat.ins_more  = (ptr_r > lo_r);
    stat.ers_more  = (ptr_inc < count_r);
    stat.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;

endmodule
`default_nettype wire

// ----- design/ordered_set_kth_largest.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_set_kth_largest: sorted set of distinct keys with rank query
// Holds up to CAPACITY distinct signed keys in ascending order in a memory.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_func, in_operand) carries one
// operation per transfer: insert a key, erase a key, or query the k-th
// largest key (rank 1 is the largest). Every item gives exactly one result
// on the output channel (out_valid, out_stall, out_status, out_value,
// out_count), in order.
// One item is worked on at a time, and in_stall stays high until its result
// moves to the output register. Each item is accepted, dispatched and handed
// off, and out_valid rises after the hand-off. A query adds a read of the
// memory. An insert or erase adds a binary search over the n keys held;
// when a key is moved in or out, each larger key is read and then written
// one place over, and a last step writes the key of an insert and updates
// the key count. A rejected rank or an unused code adds nothing.
// The hand-off waits only while an earlier result is still stalled. Reset
// empties the set at once: the key count clears and the memory is not
// swept. While out_stall is high the output holds its value.
// ----------------------------------------------------------------------------
module ordered_set_kth_largest
  import osk_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_func,
  input  wire logic signed [31:0] in_operand,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_status,
  output logic signed      [31:0] out_value,
  output logic             [8:0]  out_count
);

  localparam logic [8:0] CAP9 = 9'(CAPACITY);

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  osk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  osk_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_func),
    .in_operand (in_operand),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_value  (out_value),
    .out_count  (out_count)
  );

  // A dropped insert reports a full set.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == CAP9))
    else $error("full status without a full count");

  // A rejected rank gives a zero value.
  a_rank_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_RANK) |-> (out_value == 32'sd0))
    else $error("rank error with a nonzero value");

  // An accepted item keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // The memory is never written while the block waits for an item.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(cmd.ins_wr || cmd.ers_wr || cmd.key_wr || cmd.cnt_inc))
    else $error("key store changed while idle");

endmodule
`default_nettype wire
